// ----- hdl/bgrpf_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// bgrpf_pkg - shared types and constants for the palette fade/blend pipeline
// Item formats, configuration set, mode codes and inter-stage payloads.
// ---------------------------------------------------------------------------
package bgrpf_pkg;

	// Default geometry of the palette
	localparam int unsigned PALETTE_COLORS_DEF = 256;
	localparam int unsigned ROW_COLORS_DEF     = 16;

	// Rows covered by a skip mask
	localparam int unsigned MASK_ROWS = 16;
	localparam int unsigned ROW_W     = $clog2(MASK_ROWS);

	// Widths
	localparam int unsigned CHAN_W  = 5;
	localparam int unsigned COLOR_W = 15;
	localparam int unsigned INDEX_W = 8;
	localparam int unsigned STEP_W  = 6;
	localparam int unsigned WGT_W   = 8;
	localparam int unsigned MASK_W  = 16;
	localparam int unsigned MODE_W  = 3;
	localparam int unsigned CIDX_W  = 3;
	localparam int unsigned CDATA_W = 16;
	localparam int unsigned PROD_W  = CHAN_W + STEP_W - 1;   // 31*32 fits in 10 bits
	localparam int unsigned MPROD_W = CHAN_W + WGT_W;        // 31*255
	localparam int unsigned MSUM_W  = MPROD_W + 2;           // sum of three products

	// Channel and blend constants
	localparam logic [CHAN_W-1:0] CMAX     = 5'd31;
	localparam logic [STEP_W-1:0] STEP_MAX = 6'd32;
	localparam logic [CHAN_W:0]   TINT_ADD = 6'd5;

	// Monochrome /3: clamp when sum >= 96, else reciprocal multiply on 7 bits
	localparam logic [MSUM_W-1:0] MONO_CLAMP_SUM = 15'd96;
	localparam int unsigned       DIV3_IN_W      = 7;
	localparam logic [7:0]        DIV3_RECIP     = 8'd171;
	localparam int unsigned       DIV3_SHIFT     = 9;

	// Effect modes
	localparam logic [MODE_W-1:0] MODE_FROM_BLACK = 3'd0;
	localparam logic [MODE_W-1:0] MODE_TO_BLACK   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FROM_WHITE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_TO_WHITE   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CROSS      = 3'd4;
	localparam logic [MODE_W-1:0] MODE_MONO       = 3'd5;
	localparam logic [MODE_W-1:0] MODE_TINT       = 3'd6;

	// Register indexes
	localparam logic [CIDX_W-1:0] REG_EFFECT_MODE  = 3'd0;
	localparam logic [CIDX_W-1:0] REG_FADE_STEP    = 3'd1;
	localparam logic [CIDX_W-1:0] REG_BG_SKIP      = 3'd2;
	localparam logic [CIDX_W-1:0] REG_OBJ_SKIP     = 3'd3;
	localparam logic [CIDX_W-1:0] REG_MONO_RED_W   = 3'd4;
	localparam logic [CIDX_W-1:0] REG_MONO_GREEN_W = 3'd5;
	localparam logic [CIDX_W-1:0] REG_MONO_BLUE_W  = 3'd6;

	typedef logic [CHAN_W-1:0] chan_t;

	typedef struct packed {
		logic [COLOR_W-1:0] source_color;
		logic [COLOR_W-1:0] target_color;
		logic               is_object;
		logic [INDEX_W-1:0] color_index;
	} in_item_t;

	typedef struct packed {
		logic [COLOR_W-1:0] result_color;
		logic               write_enable;
	} out_item_t;

	typedef struct packed {
		logic [MODE_W-1:0] effect_mode;
		logic [STEP_W-1:0] fade_step;
		logic [MASK_W-1:0] bg_skip_rows;
		logic [MASK_W-1:0] obj_skip_rows;
		logic [WGT_W-1:0]  mono_red_weight;
		logic [WGT_W-1:0]  mono_green_weight;
		logic [WGT_W-1:0]  mono_blue_weight;
	} cfg_t;

	// Stage 1: decoded operands
	typedef struct packed {
		logic               skip;
		logic [COLOR_W-1:0] src;
		chan_t [2:0]        oper;
		logic [2:0]         up;
		logic [STEP_W-1:0]  step;
	} s1_t;

	// Stage 2: products
	typedef struct packed {
		logic                      skip;
		logic [COLOR_W-1:0]        src;
		logic [2:0]                up;
		logic [2:0][PROD_W-1:0]    prod;
		logic [2:0][MPROD_W-1:0]   mprod;
	} s2_t;

	// Stage 3: channel results and monochrome sum
	typedef struct packed {
		logic               skip;
		logic [COLOR_W-1:0] src;
		chan_t [2:0]        chan;
		logic [MSUM_W-1:0]  msum;
	} s3_t;

	// Channel k of a packed colour (red 0, green 1, blue 2)
	function automatic chan_t chan_of(input logic [COLOR_W-1:0] c, input int unsigned k);
		chan_of = c[k*CHAN_W +: CHAN_W];
	endfunction

endpackage : bgrpf_pkg
`default_nettype wire

// ----- hdl/bgr555_palette_fade_blend.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// bgr555_palette_fade_blend - 15-bit palette colour fade and blend unit
// Fades, cross-fade, weighted monochrome and yellow tint per palette entry.
// ---------------------------------------------------------------------------
// Use:
//   Request channel: an item (source colour, target colour, palette select,
//   colour index) is taken on a rising edge with start high and busy low.
//   busy is never raised, so one item can be taken every cycle.
//   Result channel: done pulses for one cycle with the effect colour and its
//   write enable on result. The receiver cannot stall; none is needed since
//   the pipeline never backs up.
//   Pipeline: start to done passes the decode, multiply, combine and output
//   registers. Throughput: one item per cycle, set by the four-stage pipeline
//   with two narrow multipliers per channel in stage 2.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high;
//   write only while no item is in flight. Unknown indexes are ignored.
//   Reset: arst_n clears the pipeline valid bits and loads register defaults
//   (mode from black, step 0, no skipped rows, monochrome weights 1).
// ---------------------------------------------------------------------------
module bgr555_palette_fade_blend #(
	parameter int unsigned PALETTE_COLORS = bgrpf_pkg::PALETTE_COLORS_DEF,
	parameter int unsigned ROW_COLORS     = bgrpf_pkg::ROW_COLORS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire bgrpf_pkg::in_item_t               request,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [bgrpf_pkg::CIDX_W-1:0]      cfg_index,
	input  wire logic [bgrpf_pkg::CDATA_W-1:0]     cfg_data,
	output logic                                   done,
	output bgrpf_pkg::out_item_t                   result
);
	import bgrpf_pkg::*;

	cfg_t cfg_q;
	logic take;
	logic valid_s1;
	logic valid_s2;
	s1_t  st_s1;
	s2_t  st_s2;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign take      = start && !busy;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.effect_mode       <= MODE_FROM_BLACK;
			cfg_q.fade_step         <= '0;
			cfg_q.bg_skip_rows      <= '0;
			cfg_q.obj_skip_rows     <= '0;
			cfg_q.mono_red_weight   <= WGT_W'(1);
			cfg_q.mono_green_weight <= WGT_W'(1);
			cfg_q.mono_blue_weight  <= WGT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_EFFECT_MODE:  cfg_q.effect_mode       <= cfg_data[MODE_W-1:0];
				REG_FADE_STEP:    cfg_q.fade_step         <= cfg_data[STEP_W-1:0];
				REG_BG_SKIP:      cfg_q.bg_skip_rows      <= cfg_data[MASK_W-1:0];
				REG_OBJ_SKIP:     cfg_q.obj_skip_rows     <= cfg_data[MASK_W-1:0];
				REG_MONO_RED_W:   cfg_q.mono_red_weight   <= cfg_data[WGT_W-1:0];
				REG_MONO_GREEN_W: cfg_q.mono_green_weight <= cfg_data[WGT_W-1:0];
				REG_MONO_BLUE_W:  cfg_q.mono_blue_weight  <= cfg_data[WGT_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline
	bgrpf_decode #(
		.PALETTE_COLORS(PALETTE_COLORS),
		.ROW_COLORS    (ROW_COLORS)
	) u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.take    (take),
		.request (request),
		.valid_s1(valid_s1),
		.st_s1   (st_s1)
	);

	bgrpf_mult u_mult (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.valid_s1(valid_s1),
		.st_s1   (st_s1),
		.valid_s2(valid_s2),
		.st_s2   (st_s2)
	);

	bgrpf_combine u_combine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.valid_s2(valid_s2),
		.st_s2   (st_s2),
		.done    (done),
		.result  (result)
	);

	// Every taken item is followed by its done strobe
	a_taken_done: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##4 done)
		else $error("taken item did not complete after four cycles");

	// No result without a matching item taken before it
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!take |-> ##4 !done)
		else $error("result strobe without a matching item");

	// An unwritten entry carries its source colour through unchanged
	a_skip_src: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.write_enable) |->
			(result.result_color == $past(request.source_color, 4)))
		else $error("skipped entry does not return its source colour");

endmodule : bgr555_palette_fade_blend
`default_nettype wire

// ----- hdl/bgrpf_decode.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// bgrpf_decode - stage 1 of the fade/blend pipeline
// Index table lookup, row skip decision, step clamp and per-channel operands.
// ---------------------------------------------------------------------------
module bgrpf_decode #(
	parameter int unsigned PALETTE_COLORS = bgrpf_pkg::PALETTE_COLORS_DEF,
	parameter int unsigned ROW_COLORS     = bgrpf_pkg::ROW_COLORS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire bgrpf_pkg::cfg_t    cfg,
	input  wire logic               take,
	input  wire bgrpf_pkg::in_item_t request,
	output logic                    valid_s1,
	output bgrpf_pkg::s1_t          st_s1
);
	import bgrpf_pkg::*;

	localparam int unsigned IDX_N = 1 << INDEX_W;

	// Constant index tables: row number, row inside mask, first colour of row
	logic [ROW_W-1:0] row_tab   [IDX_N];
	logic             inmask_tab[IDX_N];
	logic             first_tab [IDX_N];

	for (genvar i = 0; i < IDX_N; i++) begin : g_tab
		localparam int unsigned POS = i % PALETTE_COLORS;
		localparam int unsigned ROW = POS / ROW_COLORS;
		assign row_tab[i]    = ROW_W'(ROW % MASK_ROWS);
		assign inmask_tab[i] = (ROW < MASK_ROWS);
		assign first_tab[i]  = ((POS % ROW_COLORS) == 0);
	end

	logic [MASK_W-1:0] mask;
	logic              row_skip;
	logic              tint_first;
	s1_t               nxt;

	// Skip decision
	always_comb begin
		mask       = request.is_object ? cfg.obj_skip_rows : cfg.bg_skip_rows;
		row_skip   = inmask_tab[request.color_index] && mask[row_tab[request.color_index]];
		tint_first = (cfg.effect_mode == MODE_TINT) && first_tab[request.color_index];
	end

	// Operands per channel
	always_comb begin
		chan_t c;
		chan_t e;
		nxt.skip = row_skip || tint_first || (cfg.effect_mode > MODE_TINT);
		nxt.src  = request.source_color;
		nxt.step = (cfg.fade_step > STEP_MAX) ? STEP_MAX : cfg.fade_step;
		for (int k = 0; k < 3; k++) begin
			c = chan_of(request.source_color, k);
			e = chan_of(request.target_color, k);
			nxt.up[k]   = 1'b0;
			nxt.oper[k] = c;
			case (cfg.effect_mode) inside
				MODE_FROM_WHITE, MODE_TO_WHITE: begin
					nxt.oper[k] = CMAX - c;
				end
				MODE_CROSS: begin
					nxt.up[k]   = (e > c);
					nxt.oper[k] = (e > c) ? (e - c) : (c - e);
				end
				default: begin
					nxt.oper[k] = c;
				end
			endcase
		end
	end

	// Stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			st_s1 <= nxt;
		end
	end

endmodule : bgrpf_decode
`default_nettype wire

// ----- hdl/bgrpf_mult.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// bgrpf_mult - stage 2 of the fade/blend pipeline
// Step products for fades and cross-fade, weighted products for monochrome.
// ---------------------------------------------------------------------------
module bgrpf_mult (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire bgrpf_pkg::cfg_t cfg,
	input  wire logic            valid_s1,
	input  wire bgrpf_pkg::s1_t  st_s1,
	output logic                 valid_s2,
	output bgrpf_pkg::s2_t       st_s2
);
	import bgrpf_pkg::*;

	s2_t nxt;
	logic [2:0][WGT_W-1:0] wgt;

	assign wgt = {cfg.mono_blue_weight, cfg.mono_green_weight, cfg.mono_red_weight};

	// Six narrow multipliers in parallel
	always_comb begin
		nxt.skip = st_s1.skip;
		nxt.src  = st_s1.src;
		nxt.up   = st_s1.up;
		for (int k = 0; k < 3; k++) begin
			nxt.prod[k]  = PROD_W'(st_s1.oper[k]) * PROD_W'(st_s1.step);
			nxt.mprod[k] = MPROD_W'(chan_of(st_s1.src, k)) * MPROD_W'(wgt[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			st_s2 <= nxt;
		end
	end

endmodule : bgrpf_mult
`default_nettype wire

// ----- hdl/bgrpf_combine.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// bgrpf_combine - stages 3 and 4 of the fade/blend pipeline
// Channel combine per mode, monochrome sum, then divide/clamp and output.
// ---------------------------------------------------------------------------
module bgrpf_combine (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bgrpf_pkg::cfg_t  cfg,
	input  wire logic             valid_s2,
	input  wire bgrpf_pkg::s2_t   st_s2,
	output logic                  done,
	output bgrpf_pkg::out_item_t  result
);
	import bgrpf_pkg::*;

	s3_t       nxt3;
	s3_t       st_s3;
	logic      valid_s3;
	logic      valid_s4;
	out_item_t nxt4;
	out_item_t result_s4;

	// Stage 3: per-channel result
	always_comb begin
		chan_t            c;
		chan_t            d;
		logic [CHAN_W:0]  tsum;
		nxt3.skip = st_s2.skip;
		nxt3.src  = st_s2.src;
		nxt3.msum = MSUM_W'(st_s2.mprod[0]) + MSUM_W'(st_s2.mprod[1])
		          + MSUM_W'(st_s2.mprod[2]);
		for (int k = 0; k < 3; k++) begin
			c    = chan_of(st_s2.src, k);
			d    = st_s2.prod[k][PROD_W-1 -: CHAN_W];
			tsum = {1'b0, c} + TINT_ADD;
			case (cfg.effect_mode)
				MODE_FROM_BLACK: nxt3.chan[k] = d;
				MODE_TO_BLACK:   nxt3.chan[k] = c - d;
				MODE_FROM_WHITE: nxt3.chan[k] = CMAX - d;
				MODE_TO_WHITE:   nxt3.chan[k] = c + d;
				MODE_CROSS:      nxt3.chan[k] = st_s2.up[k] ? (c + d) : (c - d);
				MODE_TINT: begin
					// blue is left as it is
					if (k == 2) begin
						nxt3.chan[k] = c;
					end else begin
						nxt3.chan[k] = tsum[CHAN_W] ? CMAX : tsum[CHAN_W-1:0];
					end
				end
				default:         nxt3.chan[k] = c;
			endcase
		end
	end

	// Stage 4: monochrome divide by three with clamp, final select
	always_comb begin
		logic [DIV3_IN_W+7:0] q;
		chan_t                avg;
		q   = (DIV3_IN_W+8)'(st_s3.msum[DIV3_IN_W-1:0]) * (DIV3_IN_W+8)'(DIV3_RECIP);
		avg = (st_s3.msum >= MONO_CLAMP_SUM) ? CMAX : q[DIV3_SHIFT +: CHAN_W];
		if (st_s3.skip) begin
			nxt4.result_color = st_s3.src;
			nxt4.write_enable = 1'b0;
		end else if (cfg.effect_mode == MODE_MONO) begin
			nxt4.result_color = {avg, avg, avg};
			nxt4.write_enable = 1'b1;
		end else begin
			nxt4.result_color = {st_s3.chan[2], st_s3.chan[1], st_s3.chan[0]};
			nxt4.write_enable = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			st_s3 <= nxt3;
		end
		if (valid_s3) begin
			result_s4 <= nxt4;
		end
	end

	assign done   = valid_s4;
	assign result = result_s4;

endmodule : bgrpf_combine
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb - self-checking bench for the palette fade/blend unit
// Drives colour items with random gaps, programs the effect registers
// between phases and checks each result against a local colour predictor.
// ---------------------------------------------------------------------------
module tb;
	import bgrpf_pkg::*;

	localparam int unsigned ROW_COLORS   = ROW_COLORS_DEF;
	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam int unsigned RAND_PHASES  = 26;
	localparam int unsigned PHASE_ITEMS  = 50;
	localparam int unsigned IDLE_PCT     = 38;
	localparam logic [CIDX_W-1:0] REG_UNUSED  = 3'd7;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

	// Colour predictor with its own copy of the effect registers
	class fade_scoreboard;
		logic [MODE_W-1:0] mode;
		logic [STEP_W-1:0] step;
		logic [MASK_W-1:0] bg_rows;
		logic [MASK_W-1:0] obj_rows;
		logic [WGT_W-1:0]  red_w;
		logic [WGT_W-1:0]  green_w;
		logic [WGT_W-1:0]  blue_w;
		out_item_t         expected_colors[$];
		int                errors;
		int                noted;
		int                checked;
		int                reg_writes;

		function new();
			mode     = MODE_FROM_BLACK;
			step     = '0;
			bg_rows  = '0;
			obj_rows = '0;
			red_w    = 8'd1;
			green_w  = 8'd1;
			blue_w   = 8'd1;
		endfunction

		function void write_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
			reg_writes++;
			case (idx)
				REG_EFFECT_MODE:  mode     = data[MODE_W-1:0];
				REG_FADE_STEP:    step     = data[STEP_W-1:0];
				REG_BG_SKIP:      bg_rows  = data[MASK_W-1:0];
				REG_OBJ_SKIP:     obj_rows = data[MASK_W-1:0];
				REG_MONO_RED_W:   red_w    = data[WGT_W-1:0];
				REG_MONO_GREEN_W: green_w  = data[WGT_W-1:0];
				REG_MONO_BLUE_W:  blue_w   = data[WGT_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned fade_level(int unsigned c, int unsigned s);
			case (mode)
				MODE_FROM_BLACK: return (c * s) / 32;
				MODE_TO_BLACK:   return c - (c * s) / 32;
				MODE_FROM_WHITE: return 31 - ((31 - c) * s) / 32;
				default:         return c + ((31 - c) * s) / 32;
			endcase
		endfunction

		// Move from a toward e by s/32 of the distance, truncated
		function int unsigned cross_level(int unsigned a, int unsigned e, int unsigned s);
			if (e > a)
				return a + (s * (e - a)) / 32;
			return a - (s * (a - e)) / 32;
		endfunction

		function logic [COLOR_W-1:0] pack_color(int unsigned r, int unsigned g,
				int unsigned b);
			logic [COLOR_W-1:0] c;
			c = COLOR_W'(((b & 31) << 10) | ((g & 31) << 5) | (r & 31));
			return c;
		endfunction

		function out_item_t blend_color(in_item_t it);
			out_item_t   o;
			int unsigned s, row, mask, r, g, b, tr, tg, tbl, avg, nr, ng;
			s    = (step > STEP_MAX) ? 32 : step;
			row  = it.color_index / ROW_COLORS;
			mask = it.is_object ? obj_rows : bg_rows;
			r    = it.source_color[4:0];
			g    = it.source_color[9:5];
			b    = it.source_color[14:10];
			tr   = it.target_color[4:0];
			tg   = it.target_color[9:5];
			tbl  = it.target_color[14:10];
			o.result_color = it.source_color;
			o.write_enable = 1'b1;
			if (row < MASK_ROWS && ((mask >> row) & 1)) begin
				o.write_enable = 1'b0;
			end else begin
				case (mode)
					MODE_FROM_BLACK, MODE_TO_BLACK, MODE_FROM_WHITE, MODE_TO_WHITE: begin
						o.result_color = pack_color(fade_level(r, s), fade_level(g, s),
							fade_level(b, s));
					end
					MODE_CROSS: begin
						o.result_color = pack_color(cross_level(r, tr, s),
							cross_level(g, tg, s), cross_level(b, tbl, s));
					end
					MODE_MONO: begin
						avg = (r * red_w + g * green_w + b * blue_w) / 3;
						if (avg > 31)
							avg = 31;
						o.result_color = pack_color(avg, avg, avg);
					end
					MODE_TINT: begin
						// first colour of each row is left alone
						if (it.color_index % ROW_COLORS == 0) begin
							o.write_enable = 1'b0;
						end else begin
							nr = (r + 5 > 31) ? 31 : r + 5;
							ng = (g + 5 > 31) ? 31 : g + 5;
							o.result_color = pack_color(nr, ng, b);
						end
					end
					default: o.write_enable = 1'b0;
				endcase
			end
			return o;
		endfunction

		function void note_request(in_item_t it);
			expected_colors.push_back(blend_color(it));
			noted++;
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_colors.size() == 0) begin
				$error("result with nothing pending: colour %h, we %b",
					got.result_color, got.write_enable);
				errors++;
				return;
			end
			want = expected_colors.pop_front();
			checked++;
			if (got.result_color !== want.result_color) begin
				$error("result_color: expected %h, actual %h", want.result_color,
					got.result_color);
				errors++;
			end
			if (got.write_enable !== want.write_enable) begin
				$error("write_enable: expected %b, actual %b", want.write_enable,
					got.write_enable);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	in_item_t          request;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CIDX_W-1:0] cfg_index;
	logic [CDATA_W-1:0] cfg_data;
	logic              done;
	out_item_t         result;

	fade_scoreboard    sb = new();
	int unsigned       idle_pct;
	int unsigned       quiet_cycles = 0;
	bit [7:0]          modes_seen;

	bgr555_palette_fade_blend u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Monitor: accepted items, results and register writes
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(result);
			if (start && !busy)
				sb.note_request(request);
			if (cfg_valid && cfg_ready) begin
				sb.write_reg(cfg_index, cfg_data);
				if (cfg_index == REG_EFFECT_MODE)
					modes_seen[cfg_data[MODE_W-1:0]] = 1'b1;
			end
		end
	end

	// Watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Watchdog: no progress for %0d cycles", QUIET_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// One colour item; start stays high between back-to-back items
	task automatic send_color(input in_item_t it);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		start   <= 1'b1;
		request <= it;
		do
			@(posedge clk);
		while (busy);
	endtask

	function automatic in_item_t make_color(logic [COLOR_W-1:0] src,
			logic [COLOR_W-1:0] tgt, logic obj, logic [INDEX_W-1:0] idx);
		in_item_t it;
		it.source_color = src;
		it.target_color = tgt;
		it.is_object    = obj;
		it.color_index  = idx;
		return it;
	endfunction

	function automatic logic [COLOR_W-1:0] random_rgb();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return COLOR_W'($urandom);
		endcase
	endfunction

	function automatic in_item_t random_color();
		in_item_t it;
		it = make_color(random_rgb(), random_rgb(), 1'($urandom),
			INDEX_W'($urandom));
		if ($urandom_range(7) == 0)
			it.color_index[3:0] = '0;
		return it;
	endfunction

	// Stop issuing and wait until every pending colour has come back
	task automatic drain_pipe();
		start <= 1'b0;
		do
			@(posedge clk);
		while (sb.expected_colors.size() != 0);
	endtask

	// Register write; cfg_valid is left high for a following write
	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	function automatic logic [CDATA_W-1:0] pick_weight();
		case ($urandom_range(4))
			0:       return CDATA_W'(0);
			1:       return CDATA_W'(255);
			2:       return CDATA_W'(1);
			default: return CDATA_W'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [CDATA_W-1:0] pick_mask();
		case ($urandom_range(4))
			0:       return '0;
			1:       return '1;
			2:       return CDATA_W'($urandom & $urandom & $urandom);
			default: return CDATA_W'($urandom);
		endcase
	endfunction

	// New random setting; unused upper data bits of the mode, step and red weight writes carry noise
	task automatic random_setting();
		logic [CDATA_W-1:0] data;
		drain_pipe();
		repeat ($urandom_range(3)) @(posedge clk);
		data = CDATA_W'($urandom);
		data[MODE_W-1:0] = ($urandom_range(9) == 0) ? MODE_UNUSED : MODE_W'($urandom_range(6));
		write_reg(REG_EFFECT_MODE, data);
		if ($urandom_range(1)) begin
			data = CDATA_W'($urandom);
			case ($urandom_range(4))
				0:       data[STEP_W-1:0] = '0;
				1:       data[STEP_W-1:0] = STEP_MAX;
				2:       data[STEP_W-1:0] = '1;
				3:       data[STEP_W-1:0] = STEP_W'($urandom_range(63, 33));
				default: data[STEP_W-1:0] = STEP_W'($urandom_range(32));
			endcase
			write_reg(REG_FADE_STEP, data);
		end
		if ($urandom_range(1))
			write_reg(REG_BG_SKIP, pick_mask());
		if ($urandom_range(1))
			write_reg(REG_OBJ_SKIP, pick_mask());
		if ($urandom_range(1)) begin
			data = CDATA_W'($urandom);
			data[WGT_W-1:0] = pick_weight();
			write_reg(REG_MONO_RED_W, data);
		end
		if ($urandom_range(1))
			write_reg(REG_MONO_GREEN_W, pick_weight());
		if ($urandom_range(1))
			write_reg(REG_MONO_BLUE_W, pick_weight());
		if ($urandom_range(9) == 0)
			write_reg(REG_UNUSED, CDATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		request   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		idle_pct  = IDLE_PCT;
		modes_seen = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset defaults: from black at step zero
		send_color(make_color('1, '1, 1'b0, 8'h01));
		send_color(make_color('1, '0, 1'b1, 8'hFF));

		// Monochrome with the reset weights
		drain_pipe();
		write_reg(REG_EFFECT_MODE, CDATA_W'(MODE_MONO));
		cfg_valid <= 1'b0;
		send_color(make_color('1, '0, 1'b0, 8'h12));
		send_color(make_color(15'h1234, '1, 1'b1, 8'h23));

		// Step above full scale, skipped rows, extreme weights
		drain_pipe();
		write_reg(REG_FADE_STEP, CDATA_W'(63));
		write_reg(REG_BG_SKIP, CDATA_W'(16'h8001));
		write_reg(REG_OBJ_SKIP, CDATA_W'(16'h0002));
		write_reg(REG_MONO_RED_W, CDATA_W'(255));
		write_reg(REG_MONO_GREEN_W, CDATA_W'(0));
		write_reg(REG_MONO_BLUE_W, CDATA_W'(255));
		cfg_valid <= 1'b0;
		for (int m = 0; m < 8; m++) begin
			drain_pipe();
			write_reg(REG_EFFECT_MODE, CDATA_W'(m));
			cfg_valid <= 1'b0;
			send_color(make_color('1, '0, 1'b0, 8'h11));
			send_color(make_color('0, '1, 1'b1, 8'h31));
		end
		// still in the unused mode; move to tint for the row cases
		drain_pipe();
		write_reg(REG_EFFECT_MODE, CDATA_W'(MODE_TINT));
		cfg_valid <= 1'b0;
		send_color(make_color(15'h3DEF, '0, 1'b0, 8'h00));
		send_color(make_color(15'h3DEF, '0, 1'b0, 8'hF7));
		send_color(make_color(15'h3DEF, '0, 1'b1, 8'h1A));
		send_color(make_color(15'h56B5, '0, 1'b1, 8'h40));

		// Random phases, four of them without sender gaps
		for (int p = 0; p < RAND_PHASES; p++) begin
			idle_pct = (p >= 10 && p < 14) ? 0 : IDLE_PCT;
			random_setting();
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_color(random_color());
		end

		drain_pipe();
		repeat (8) @(posedge clk);
		$display("Checked %0d of %0d colour items over %0d register writes",
			sb.checked, sb.noted, sb.reg_writes);
		$display("Effect mode codes exercised: %b (bit per code)", modes_seen);
		if (sb.errors == 0 && sb.expected_colors.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/bgrpf_pkg.sv
hdl/bgrpf_decode.sv
hdl/bgrpf_mult.sv
hdl/bgrpf_combine.sv
hdl/bgr555_palette_fade_blend.sv
sim/tb.sv
